// File: design/sha_bsh_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher - shared definitions
// Transfer types, control bundle, FSM states, round constants and sigma
// functions used by the controller and the datapath.
// ----------------------------------------------------------------------------
package sha_bsh_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumWrd  = 8;
  localparam int unsigned SchDep  = 16;
  localparam int unsigned LenW    = 61;

  localparam logic [7:0] PadMark   = 8'h80;
  localparam logic [5:0] LenStart  = 6'd56;
  localparam logic [5:0] LastByte  = 6'd63;
  localparam logic [5:0] LastRound = 6'd63;
  localparam logic [2:0] LastWord  = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic       shift_byte;
    logic [7:0] byte_val;
    logic       load;
    logic       round;
    logic [5:0] rnd;
    logic       add;
    logic       reset_h;
    logic [2:0] rd_idx;
  } ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_e;

  localparam logic [31:0] InitH [NumWrd] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

endpackage

// File: design/sha256_byte_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Takes a message one byte per transfer and returns the eight digest words.
// ----------------------------------------------------------------------------
//
//   channel | direction | payload                                 | handshake
//   --------+-----------+-----------------------------------------+----------------------
//   in      | input     | data_byte, byte_present, last_byte      | in_valid_i/in_stall_o
//   out     | output    | digest_word, word_index, last_word      | out_valid_o/out_stall_i
//
// Flow: an input transfer that does not complete a 64-byte block leaves the
// sequencer idle. A transfer that completes a block runs the shared round unit
// for 64 rounds plus one chaining add before the next transfer is taken.
// On the last transfer padding and the length are shifted into the schedule
// one byte per cycle (over a second block when the length does not fit), each
// block is compressed in the round unit in turn, then eight digest words
// follow, one per cycle when not stalled.
// Reset: asynchronous, active low; chaining words return to the SHA-256
// initial values, counters and length clear. No clearing pass.
// Stalls: in_stall_o is high whenever the sequencer is not idle, including
// while digest words are offered; out_stall_i holds the current word.
//
module sha256_byte_stream_hasher_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sha_bsh_pkg::in_t    in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sha_bsh_pkg::out_t   out_data_o
);
  import sha_bsh_pkg::*;

  ctl_t        ctl;
  logic [31:0] w_cur;
  logic [31:0] digest;
  logic [2:0]  widx;

  // sequencer: intake, padding, round count, output order
  sha_bsh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .widx_o     (widx),
    .ctl_o      (ctl)
  );

  // message bytes land here and become the schedule words
  sha_bsh_sched u_sched (
    .clk_i(clk_i),
    .ctl_i(ctl),
    .w_o  (w_cur)
  );

  // one SHA-256 round per cycle, chaining words held here
  sha_bsh_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .w_i     (w_cur),
    .digest_o(digest)
  );

  // digest words come straight from the chaining registers, which hold
  // while the output is stalled
  always_comb begin
    out_data_o.digest_word = digest;
    out_data_o.word_index  = widx;
    out_data_o.last_word   = (widx == LastWord);
  end

endmodule

// File: design/sha_bsh_sched.sv
// ----------------------------------------------------------------------------
// SHA-256 message schedule
// 16-word shift line: takes message bytes one at a time, then during the
// rounds shifts one word per cycle and appends the next schedule word.
// ----------------------------------------------------------------------------
module sha_bsh_sched (
  input  logic                clk_i,
  input  sha_bsh_pkg::ctl_t   ctl_i,
  output logic [31:0]         w_o
);
  import sha_bsh_pkg::*;

  logic [31:0] w_q [SchDep];
  logic [31:0] w_new;

  assign w_new = w_q[0] + ssig0(w_q[1]) + w_q[9] + ssig1(w_q[14]);
  assign w_o   = w_q[0];

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift_byte) begin
      for (int i = 0; i < SchDep - 1; i++) begin
        w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
      end
      w_q[SchDep-1] <= {w_q[SchDep-1][23:0], ctl_i.byte_val};
    end else if (ctl_i.round) begin
      for (int i = 0; i < SchDep - 1; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[SchDep-1] <= w_new;
    end
  end

endmodule

// File: design/sha_bsh_core.sv
// ----------------------------------------------------------------------------
// SHA-256 round core
// Working variables a..h updated by one round per cycle, chaining words
// updated by the final add, digest word read port.
// ----------------------------------------------------------------------------
module sha_bsh_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sha_bsh_pkg::ctl_t  ctl_i,
  input  logic [31:0]        w_i,
  output logic [31:0]        digest_o
);
  import sha_bsh_pkg::*;

  logic [31:0] h_q [NumWrd];
  logic [31:0] v_q [NumWrd];
  logic [31:0] t1, t2, ch, maj;

  always_comb begin
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1  = v_q[7] + bsig1(v_q[4]) + ch + RoundK[ctl_i.rnd] + w_i;
    t2  = bsig0(v_q[0]) + maj;
  end

  assign digest_o = h_q[ctl_i.rd_idx];

  // chaining words reset to the initial hash
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumWrd; i++) h_q[i] <= InitH[i];
    end else if (ctl_i.reset_h) begin
      for (int i = 0; i < NumWrd; i++) h_q[i] <= InitH[i];
    end else if (ctl_i.add) begin
      for (int i = 0; i < NumWrd; i++) h_q[i] <= h_q[i] + v_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      for (int i = 0; i < NumWrd; i++) v_q[i] <= h_q[i];
    end else if (ctl_i.round) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

endmodule

// File: design/sha_bsh_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher sequencer
// Byte intake, padding and length insertion, round counting and digest
// output sequencing.
// ----------------------------------------------------------------------------
module sha_bsh_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  sha_bsh_pkg::in_t   in_data_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         widx_o,
  output sha_bsh_pkg::ctl_t  ctl_o
);
  import sha_bsh_pkg::*;

  state_e            state_q, state_d;
  logic [5:0]        fill_q, fill_d;
  logic [5:0]        rnd_q, rnd_d;
  logic [2:0]        widx_q, widx_d;
  logic [LenW-1:0]   len_q, len_d;
  logic              fin_q, fin_d;     // message end seen
  logic              mark_q, mark_d;   // 0x80 already placed
  logic              lenok_q, lenok_d; // this block carries the length
  logic [63:0]       bits;
  logic [63:0]       bits_sh;
  logic [5:0]        sh_amt;
  logic [7:0]        len_byte;

  // length field is big-endian in bytes 56..63
  assign bits     = {len_q, 3'b000};
  assign sh_amt   = {3'd7 - fill_q[2:0], 3'b000};
  assign bits_sh  = bits >> sh_amt;
  assign len_byte = bits_sh[7:0];

  assign widx_o = widx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      rnd_q   <= '0;
      widx_q  <= '0;
      len_q   <= '0;
      fin_q   <= 1'b0;
      mark_q  <= 1'b0;
      lenok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      rnd_q   <= rnd_d;
      widx_q  <= widx_d;
      len_q   <= len_d;
      fin_q   <= fin_d;
      mark_q  <= mark_d;
      lenok_q <= lenok_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    rnd_d       = rnd_q;
    widx_d      = widx_q;
    len_d       = len_q;
    fin_d       = fin_q;
    mark_d      = mark_q;
    lenok_d     = lenok_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    ctl_o       = '0;
    ctl_o.rnd   = rnd_q;
    ctl_o.rd_idx = widx_q;

    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (in_data_i.byte_present) begin
            ctl_o.shift_byte = 1'b1;
            ctl_o.byte_val   = in_data_i.data_byte;
            fill_d           = fill_q + 6'd1;
            len_d            = len_q + LenW'(1);
          end
          if (in_data_i.byte_present && fill_q == LastByte) begin
            ctl_o.load = 1'b1;
            rnd_d      = '0;
            fin_d      = in_data_i.last_byte;
            state_d    = ST_ROUND;
          end else if (in_data_i.last_byte) begin
            fin_d   = 1'b1;
            state_d = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        ctl_o.shift_byte = 1'b1;
        if (!mark_q) begin
          ctl_o.byte_val = PadMark;
          mark_d         = 1'b1;
          if (fill_q < LenStart) lenok_d = 1'b1;
        end else if (lenok_q && fill_q >= LenStart) begin
          ctl_o.byte_val = len_byte;
        end else begin
          ctl_o.byte_val = 8'h00;
        end
        fill_d = fill_q + 6'd1;
        if (fill_q == LastByte) begin
          ctl_o.load = 1'b1;
          rnd_d      = '0;
          state_d    = ST_ROUND;
        end
      end

      ST_ROUND: begin
        ctl_o.round = 1'b1;
        rnd_d       = rnd_q + 6'd1;
        if (rnd_q == LastRound) state_d = ST_ADD;
      end

      ST_ADD: begin
        ctl_o.add = 1'b1;
        if (!fin_q) begin
          state_d = ST_IDLE;
        end else if (lenok_q) begin
          widx_d  = '0;
          state_d = ST_OUT;
        end else begin
          // length goes into the next block
          lenok_d = 1'b1;
          state_d = ST_PAD;
        end
      end

      ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          widx_d = widx_q + 3'd1;
          if (widx_q == LastWord) begin
            ctl_o.reset_h = 1'b1;
            len_d         = '0;
            fill_d        = '0;
            fin_d         = 1'b0;
            mark_d        = 1'b0;
            lenok_d       = 1'b0;
            state_d       = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/sha_bsh_checker.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher port checker
// Watches the top-level ports for output ordering and busy behavior.
// ----------------------------------------------------------------------------
module sha_bsh_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input sha_bsh_pkg::in_t   in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input sha_bsh_pkg::out_t  out_data_o
);
  import sha_bsh_pkg::*;

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("digest word changed while stalled");

  // no input taken while the digest is offered
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open during digest output");

  // words come in order without gaps
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_word |=>
      out_valid_o && out_data_o.word_index == $past(out_data_o.word_index) + 3'd1)
    else $error("digest word out of order");

  // last flag only on the eighth word
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_word == (out_data_o.word_index == LastWord)))
    else $error("last_word mismatch");

  // digest ends after the last word
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_data_o.last_word |=> !out_valid_o && !in_stall_o)
    else $error("output continues after last word");

endmodule

bind sha256_byte_stream_hasher_unit sha_bsh_checker u_sha_bsh_checker (.*);

// File: tb/sha256_digest_tracker_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 digest tracker
// Bit-exact SHA-256 of the byte stream seen at the input channel, with a queue
// of the digest words still to come out and a field-by-field compare.
// ----------------------------------------------------------------------------
package sha256_digest_tracker_pkg;

  import sha_bsh_pkg::in_t;
  import sha_bsh_pkg::out_t;

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SeedHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  class sha256_digest_tracker;
    logic [31:0] chain [8];
    logic [7:0]  blk [64];
    int unsigned fill;
    logic [60:0] msg_len;
    out_t        expected_words [$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      chain   = SeedHash;
      fill    = 0;
      msg_len = '0;
    endfunction

    function logic [31:0] rotr(logic [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int i = 0; i < 16; i++) begin
        w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      end
      for (int i = 16; i < 64; i++) begin
        w[i] = w[i-16] + w[i-7]
             + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
             + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
      end
      {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                  chain[4], chain[5], chain[6], chain[7]};
      for (int r = 0; r < 64; r++) begin
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + RoundConst[r] + w[r];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    // one accepted input transfer; a last marker queues the eight digest words
    function void absorb_transfer(in_t t);
      logic [63:0] bit_len;
      out_t        word;
      if (t.byte_present) begin
        blk[fill] = t.data_byte;
        fill++;
        msg_len++;
        if (fill == 64) begin
          compress_block();
          fill = 0;
        end
      end
      if (!t.last_byte) return;

      bit_len   = {msg_len, 3'b000};
      blk[fill] = 8'h80;
      fill++;
      // no room for the length field: pad out and compress this block first
      if (fill > 56) begin
        for (int i = fill; i < 64; i++) blk[i] = 8'h00;
        compress_block();
        fill = 0;
      end
      for (int i = fill; i < 56; i++) blk[i] = 8'h00;
      for (int i = 0; i < 8; i++) blk[63-i] = bit_len[8*i +: 8];
      compress_block();

      for (int i = 0; i < 8; i++) begin
        word.digest_word = chain[i];
        word.word_index  = 3'(i);
        word.last_word   = (i == 7);
        expected_words.push_back(word);
      end
      restart();
    endfunction

    function void check_digest_word(out_t got);
      out_t want;
      if (expected_words.size() == 0) begin
        $display("%0t: digest word with none pending: expected none, actual %h",
                 $time, got);
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      if (got.digest_word !== want.digest_word) begin
        $display("%0t: digest_word expected %h actual %h",
                 $time, want.digest_word, got.digest_word);
        mismatches++;
      end
      if (got.word_index !== want.word_index) begin
        $display("%0t: word_index expected %0d actual %0d",
                 $time, want.word_index, got.word_index);
        mismatches++;
      end
      if (got.last_word !== want.last_word) begin
        $display("%0t: last_word expected %b actual %b",
                 $time, want.last_word, got.last_word);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

endpackage

// File: tb/sha256_byte_stream_hasher_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher - unit test
// Streams short directed messages and then random messages (lengths bunched
// around the padding and block boundaries) into the hasher, with random gaps
// on the input and random stalls on the output. Every digest word is checked
// against a software SHA-256 of the accepted byte stream.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_unit_test;

  import sha_bsh_pkg::in_t;
  import sha_bsh_pkg::out_t;
  import sha256_digest_tracker_pkg::sha256_digest_tracker;

  // message lengths around the interesting boundaries: 55 is the longest
  // tail that still fits the length field, 56..63 force an extra block,
  // 64 ends exactly on a block
  localparam int unsigned BoundaryLens [10] = '{54, 55, 56, 57, 62, 63, 64, 65, 119, 120};
  localparam int unsigned RandomItems = 330;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  sha256_digest_tracker tracker;
  int unsigned          items_sent;

  sha256_byte_stream_hasher_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // mostly back-to-back, often a short idle gap, now and then a long pause
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // One input transfer. Valid is only dropped when a gap precedes the item, so
  // it is never lowered and raised in the same step. Called right after a
  // rising edge; returns right after the edge that accepted the transfer.
  task automatic send_transfer(input in_t t);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    tracker.absorb_transfer(t);
  endtask

  // A whole message. The end marker rides on the final byte or comes as a
  // separate byte-less transfer; noisy sprinkles idle transfers in between.
  task automatic send_msg(input logic [7:0] msg [$], input bit last_on_byte,
                          input bit noisy);
    in_t t;
    for (int k = 0; k < msg.size(); k++) begin
      if (noisy && $urandom_range(0, 7) == 0) begin
        t = {8'($urandom), 1'b0, 1'b0};
        send_transfer(t);
        items_sent++;
      end
      t = {msg[k], 1'b1, last_on_byte && (k == msg.size() - 1)};
      send_transfer(t);
      items_sent++;
    end
    if (!last_on_byte || msg.size() == 0) begin
      // payload byte is junk here and must be ignored
      t = {8'($urandom), 1'b0, 1'b1};
      send_transfer(t);
      items_sent++;
    end
  endtask

  // output side: open stretches of random length, some long, between stalls
  initial begin
    int unsigned open_len;
    out_stall = 1'b0;
    forever begin
      open_len = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                             : $urandom_range(1, 10);
      repeat (open_len) @(posedge clk);
      out_stall <= 1'b1;
      repeat (pick_gap() + 1) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  // every digest word transfer goes to the tracker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_digest_word(out_data);
    end
  end

  initial begin
    logic [7:0]  msg [$];
    in_t         t;
    int unsigned pick;
    int unsigned len;

    tracker    = new();
    items_sent = 0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    // idle transfer with all data bits set: must leave no trace
    t = {8'hff, 1'b0, 1'b0};
    send_transfer(t);
    // empty message
    msg = {};
    send_msg(msg, 1'b0, 1'b0);
    // "abc", end marker on the last byte
    msg = {8'h61, 8'h62, 8'h63};
    send_msg(msg, 1'b1, 1'b0);
    // single zero byte with end marker
    msg = {8'h00};
    send_msg(msg, 1'b1, 1'b0);
    // 0xff, an idle transfer, then a byte-less end marker with junk data
    t = {8'hff, 1'b1, 1'b0};
    send_transfer(t);
    t = {8'h5a, 1'b0, 1'b0};
    send_transfer(t);
    t = {8'ha5, 1'b0, 1'b1};
    send_transfer(t);
    // walking one across the data byte
    msg = {8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80};
    send_msg(msg, 1'b1, 1'b0);
    items_sent = 0;

    // --- random messages, mostly short, many on block boundaries ---
    while (items_sent < RandomItems) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        len = $urandom_range(0, 12);
      end else if (pick < 18) begin
        len = BoundaryLens[$urandom_range(0, 9)];
      end else begin
        len = $urandom_range(0, 140);
      end
      msg = {};
      repeat (len) msg.push_back(8'($urandom));
      send_msg(msg, (len > 0) && ($urandom_range(0, 1) == 1), 1'b1);
    end
    in_valid <= 1'b0;

    // drain the digest words, then wait quietly for stray output
    while (tracker.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
